// ===== hw/rtl/rhap_pkg.sv =====
// shared types and constants for the rtp h264 / aac packetizer
package rhap_pkg;

  localparam int unsigned UnitLengthBitsDefault = 24;
  localparam int unsigned QueueDepth = 4;

  localparam logic [2:0] CfgMaxPayload  = 3'd0;
  localparam logic [2:0] CfgVideoPt     = 3'd1;
  localparam logic [2:0] CfgAudioPt     = 3'd2;
  localparam logic [2:0] CfgVideoSsrc   = 3'd3;
  localparam logic [2:0] CfgAudioSsrc   = 3'd4;
  localparam logic [2:0] CfgVideoChan   = 3'd5;
  localparam logic [2:0] CfgAudioChan   = 3'd6;

  localparam logic [7:0] InterleaveMagic = 8'h24;
  localparam logic [7:0] RtpVersionByte  = 8'h80;
  localparam logic [7:0] FuaType         = 8'd28;
  localparam logic [7:0] AuHeadersLen    = 8'h10;

  // packet kind chosen by the front end
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PAYLOAD,
    KIND_HEAD
  } kind_e;

  // one classified word handed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;       // payload byte
    logic        data_last;  // payload byte closes its packet
    logic        has_data;   // payload byte follows the header
    logic [7:0]  chan;
    logic [15:0] len;
    logic        mark;
    logic [6:0]  pt;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [1:0]  n_extra;    // 0 none, 2 fu bytes, 3 means au header (4 bytes)
    logic [7:0]  extra0;
    logic [7:0]  extra1;
    logic [7:0]  extra2;
    logic [7:0]  extra3;
  } work_t;

endpackage

// ===== hw/rtl/rtp_h264_aac_packetizer_unit.sv =====
// top level of the rtp h264 / aac interleaved packetizer
// Takes one media byte per word and emits interleaved RTP packet bytes. The
// front end accepts a byte every cycle while the queue has room; it emits at
// most one classified word per input. The back end sends one output byte
// per cycle while the receiver is ready: a payload word gives one byte, a
// packet start gives 17 to 20 bytes (4-byte interleave header, 12-byte RTP
// header, FU or AU header bytes, any first payload byte). Config writes are
// taken at any time and should occur only while idle.
module rtp_h264_aac_packetizer_unit #(
  parameter int unsigned UnitLengthBits = rhap_pkg::UnitLengthBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                byte_value_i,
  input  logic                      is_audio_i,
  input  logic                      unit_start_i,
  input  logic [UnitLengthBits-1:0] unit_length_i,
  input  logic [31:0]               time_ms_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      packet_end_o,
  output logic                      run_last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [2:0]                cfg_index_i,
  input  logic [31:0]               cfg_data_i
);
  logic [15:0] maxp_q;
  logic [6:0]  vpt_q, apt_q;
  logic [31:0] vssrc_q, assrc_q;
  logic [7:0]  vch_q, ach_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxp_q <= 16'd8100; vpt_q <= 7'd96; apt_q <= 7'd97;
      vssrc_q <= 32'd10000; assrc_q <= 32'd20000; vch_q <= 8'd0; ach_q <= 8'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rhap_pkg::CfgMaxPayload: maxp_q  <= cfg_data_i[15:0];
        rhap_pkg::CfgVideoPt:    vpt_q   <= cfg_data_i[6:0];
        rhap_pkg::CfgAudioPt:    apt_q   <= cfg_data_i[6:0];
        rhap_pkg::CfgVideoSsrc:  vssrc_q <= cfg_data_i;
        rhap_pkg::CfgAudioSsrc:  assrc_q <= cfg_data_i;
        rhap_pkg::CfgVideoChan:  vch_q   <= cfg_data_i[7:0];
        rhap_pkg::CfgAudioChan:  ach_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic wv, wr_rdy, rv, rr;
  rhap_pkg::work_t ww, rw;

  rhap_front #(.UnitLengthBits(UnitLengthBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .byte_value_i, .is_audio_i,
    .unit_start_i, .unit_length_i, .time_ms_i,
    .max_payload_i(maxp_q), .video_pt_i(vpt_q), .audio_pt_i(apt_q),
    .video_ssrc_i(vssrc_q), .audio_ssrc_i(assrc_q),
    .video_chan_i(vch_q), .audio_chan_i(ach_q),
    .wr_valid_o(wv), .wr_ready_i(wr_rdy), .wr_word_o(ww)
  );

  // queue decouples parsing from byte serialization
  rhap_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(wv), .wr_ready_o(wr_rdy), .wr_word_i(ww),
    .rd_valid_o(rv), .rd_ready_i(rr), .rd_word_o(rw)
  );

  rhap_back u_back (
    .clk_i, .rst_ni, .rd_valid_i(rv), .rd_ready_o(rr), .rd_word_i(rw),
    .out_valid_o, .out_ready_i, .out_byte_o, .packet_end_o, .run_last_o
  );
endmodule

// ===== hw/rtl/rhap_front.sv =====
// front end: parses media bytes, keeps stream state, classifies each word
module rhap_front #(
  parameter int unsigned UnitLengthBits = rhap_pkg::UnitLengthBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                byte_value_i,
  input  logic                      is_audio_i,
  input  logic                      unit_start_i,
  input  logic [UnitLengthBits-1:0] unit_length_i,
  input  logic [31:0]               time_ms_i,
  input  logic [15:0]               max_payload_i,
  input  logic [6:0]                video_pt_i,
  input  logic [6:0]                audio_pt_i,
  input  logic [31:0]               video_ssrc_i,
  input  logic [31:0]               audio_ssrc_i,
  input  logic [7:0]                video_chan_i,
  input  logic [7:0]                audio_chan_i,
  output logic                      wr_valid_o,
  input  logic                      wr_ready_i,
  output rhap_pkg::work_t           wr_word_o
);

  logic [15:0] vseq_q, vseq_d, aseq_q, aseq_d;
  logic [UnitLengthBits-1:0] off_q, off_d, total_q, total_d;
  logic [15:0] fill_q, fill_d, frag_q, frag_d;
  logic [7:0]  nal_q, nal_d;
  logic [31:0] vts_q, vts_d, ats_q, ats_d;
  logic        act_q, act_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [12:0] flen_q, flen_d, left_q, left_d;

  // timestamps of later packets come from the times latched at unit start
  logic [31:0] vtime_mul, atime_mul;
  assign vtime_mul = vts_q * 32'd90;
  assign atime_mul = {ats_q[27:0], 4'b0};

  logic fire;
  assign in_ready_o = wr_ready_i;
  assign fire = in_valid_i && in_ready_o;

  rhap_pkg::work_t w;
  logic emit;

  always_comb begin
    logic [UnitLengthBits-1:0] tot, off, rem, one;
    logic [15:0] frg, fill, plen;
    logic [7:0]  nal;
    logic        act, fin, lastb, single;
    logic [12:0] fl, pl;
    vseq_d = vseq_q; aseq_d = aseq_q; off_d = off_q; total_d = total_q;
    fill_d = fill_q; frag_d = frag_q; nal_d = nal_q; vts_d = vts_q;
    ats_d = ats_q; act_d = act_q; hidx_d = hidx_q; flen_d = flen_q;
    left_d = left_q;
    w = '0;
    w.kind = rhap_pkg::KIND_NONE;
    emit = 1'b0;
    one = {{(UnitLengthBits-1){1'b0}}, 1'b1};
    tot = total_q; off = off_q; frg = frag_q; fill = fill_q; nal = nal_q;
    act = act_q; rem = '0; fin = 1'b0; lastb = 1'b0; plen = '0;
    single = 1'b0; fl = flen_q; pl = '0;
    w.data = byte_value_i;
    if (is_audio_i) begin
      w.chan = audio_chan_i; w.pt = audio_pt_i; w.ssrc = audio_ssrc_i;
      w.seq = aseq_q; w.mark = 1'b1;
      w.ts = unit_start_i ? {time_ms_i[27:0], 4'b0} : atime_mul;
      if (unit_start_i) begin
        ats_d = time_ms_i;
      end
      if (!unit_start_i && left_q != 13'd0) begin
        left_d = left_q - 13'd1;
        w.kind = rhap_pkg::KIND_PAYLOAD;
        w.data_last = (left_d == 13'd0);
        emit = 1'b1;
      end else begin
        case (unit_start_i ? 3'd0 : hidx_q)
          3'd0: fl = '0;
          3'd3: fl = {byte_value_i[1:0], 11'd0};
          3'd4: fl = fl | {2'b0, byte_value_i, 3'b0};
          3'd5: fl = fl | {10'd0, byte_value_i[7:5]};
          default: ;
        endcase
        flen_d = fl;
        if ((unit_start_i ? 3'd0 : hidx_q) < 3'd6) begin
          hidx_d = (unit_start_i ? 3'd0 : hidx_q) + 3'd1;
          if (unit_start_i) left_d = '0;
        end else begin
          hidx_d = '0;
          pl = (fl > 13'd7) ? fl - 13'd7 : 13'd0;
          left_d = pl;
          aseq_d = aseq_q + 16'd1;
          w.kind = rhap_pkg::KIND_HEAD;
          w.len = {3'b0, pl} + 16'd16;
          w.n_extra = 2'd3;
          w.extra0 = 8'h00; w.extra1 = rhap_pkg::AuHeadersLen;
          w.extra2 = pl[12:5]; w.extra3 = {pl[4:0], 3'b0};
          w.data_last = (pl == 13'd0);
          emit = 1'b1;
        end
      end
    end else begin
      if (unit_start_i) begin
        tot = unit_length_i; off = '0; fill = '0; nal = byte_value_i;
        vts_d = time_ms_i;
        frg = (max_payload_i < 16'd2) ? 16'd2 : max_payload_i;
        act = (unit_length_i != '0);
      end
      w.chan = video_chan_i; w.pt = video_pt_i; w.ssrc = video_ssrc_i;
      w.seq = vseq_q;
      w.ts = unit_start_i ? time_ms_i * 32'd90 : vtime_mul;
      if (act) begin
        emit = 1'b1;
        single = (32'(tot) <= {16'd0, frg});
        lastb = (off + one == tot);
        w.extra0 = (nal & 8'he0) | rhap_pkg::FuaType;
        if (single) begin
          w.data_last = lastb;
          if (off == '0) begin
            w.kind = rhap_pkg::KIND_HEAD; w.mark = 1'b1; w.has_data = 1'b1;
            w.len = tot[15:0] + 16'd12;
            vseq_d = vseq_q + 16'd1;
          end else begin
            w.kind = rhap_pkg::KIND_PAYLOAD;
          end
        end else if (off == '0) begin
          w.kind = rhap_pkg::KIND_HEAD; w.len = frg + 16'd13;
          w.n_extra = 2'd2; w.extra1 = 8'h80 | {3'b0, nal[4:0]};
          w.has_data = 1'b0; w.data_last = 1'b0;
          vseq_d = vseq_q + 16'd1;
          fill = 16'd1;
        end else begin
          w.kind = rhap_pkg::KIND_PAYLOAD;
          if (fill >= frg) begin
            rem = tot - off;
            fin = (32'(rem) <= {16'd0, frg});
            plen = fin ? rem[15:0] : frg;
            w.kind = rhap_pkg::KIND_HEAD; w.has_data = 1'b1;
            w.len = plen + 16'd14; w.mark = fin;
            w.n_extra = 2'd2;
            w.extra1 = (fin ? 8'h40 : 8'h00) | {3'b0, nal[4:0]};
            vseq_d = vseq_q + 16'd1;
            fill = '0;
          end
          fill = fill + 16'd1;
          w.data_last = (fill >= frg) || lastb;
        end
        off = off + one;
        if (off >= tot || off == '0) act = 1'b0;
      end
      total_d = tot; off_d = off; fill_d = fill; nal_d = nal; frag_d = frg;
      act_d = act;
    end
    // an au header word ends with the au header, payload bytes follow as later words
    if (w.kind == rhap_pkg::KIND_HEAD && w.n_extra == 2'd3) w.has_data = 1'b0;
  end

  assign wr_valid_o = fire && emit;
  assign wr_word_o  = w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vseq_q <= '0; aseq_q <= 16'd10000; off_q <= '0; total_q <= '0;
      fill_q <= '0; frag_q <= '0; nal_q <= '0; vts_q <= '0; ats_q <= '0;
      act_q <= 1'b0; hidx_q <= '0; flen_q <= '0; left_q <= '0;
    end else if (fire) begin
      vseq_q <= vseq_d; aseq_q <= aseq_d; off_q <= off_d; total_q <= total_d;
      fill_q <= fill_d; frag_q <= frag_d; nal_q <= nal_d; vts_q <= vts_d;
      ats_q <= ats_d; act_q <= act_d; hidx_q <= hidx_d; flen_q <= flen_d;
      left_q <= left_d;
    end
  end

endmodule

// ===== hw/rtl/rhap_queue.sv =====
// small fifo of classified words between front and back
module rhap_queue #(
  parameter int unsigned Depth = rhap_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  rhap_pkg::work_t wr_word_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output rhap_pkg::work_t rd_word_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  rhap_pkg::work_t mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != Aw'(0) + (Aw+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_word_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == Aw'(Depth-1)) ? '0 : wp_q + Aw'(1);
      if (rd) rp_q <= (rp_q == Aw'(Depth-1)) ? '0 : rp_q + Aw'(1);
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end
endmodule

// ===== hw/rtl/rhap_back.sv =====
// back end: serializes each classified word into stream bytes
module rhap_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_valid_i,
  output logic            rd_ready_o,
  input  rhap_pkg::work_t rd_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            packet_end_o,
  output logic            run_last_o
);
  logic [4:0] idx_q, idx_d, cnt;
  rhap_pkg::work_t w;
  logic [7:0] b;
  logic pe;
  assign w = rd_word_i;

  always_comb begin
    logic [4:0] ne;
    ne = (w.n_extra == 2'd3) ? 5'd4 : ((w.n_extra == 2'd2) ? 5'd2 : 5'd0);
    if (w.kind == rhap_pkg::KIND_HEAD) cnt = 5'd16 + ne + {4'b0, w.has_data};
    else cnt = 5'd1;
    b = w.data; pe = w.data_last;
    if (w.kind == rhap_pkg::KIND_HEAD) begin
      pe = 1'b0;
      case (idx_q)
        5'd0:  b = rhap_pkg::InterleaveMagic;
        5'd1:  b = w.chan;
        5'd2:  b = w.len[15:8];
        5'd3:  b = w.len[7:0];
        5'd4:  b = rhap_pkg::RtpVersionByte;
        5'd5:  b = {w.mark, w.pt};
        5'd6:  b = w.seq[15:8];
        5'd7:  b = w.seq[7:0];
        5'd8:  b = w.ts[31:24];
        5'd9:  b = w.ts[23:16];
        5'd10: b = w.ts[15:8];
        5'd11: b = w.ts[7:0];
        5'd12: b = w.ssrc[31:24];
        5'd13: b = w.ssrc[23:16];
        5'd14: b = w.ssrc[15:8];
        5'd15: b = w.ssrc[7:0];
        5'd16: b = (ne == 5'd0) ? w.data : w.extra0;
        5'd17: b = w.extra1;
        5'd18: b = (ne == 5'd2) ? w.data : w.extra2;
        5'd19: b = w.extra3;
        default: b = w.data;
      endcase
      if (idx_q == cnt - 5'd1) pe = (ne == 5'd2 && !w.has_data) ? 1'b0 : w.data_last;
    end
    idx_d = idx_q;
    if (rd_valid_i && out_ready_i) idx_d = (idx_q == cnt - 5'd1) ? 5'd0 : idx_q + 5'd1;
  end

  assign out_valid_o  = rd_valid_i;
  assign out_byte_o   = b;
  assign packet_end_o = pe;
  assign run_last_o   = (idx_q == cnt - 5'd1);
  assign rd_ready_o   = out_ready_i && (idx_q == cnt - 5'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else idx_q <= idx_d;
  end

  prop_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < 5'd21) else $error("byte index out of range");
  prop_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(idx_q)) else $error("index moved on stall");
  prop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && packet_end_o) |-> run_last_o) else $error("packet end before run end");
endmodule

// ===== sim/tb_rtp_h264_aac_packetizer_unit.sv =====
// testbench for the rtp h264 / aac interleaved packetizer
`timescale 1ns / 1ps

module tb_rtp_h264_aac_packetizer_unit;

  localparam int unsigned LenBits    = rhap_pkg::UnitLengthBitsDefault;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 60;   // cycles of back end work after the last word
  localparam int unsigned RandItems  = 210;

  // one expected output word
  typedef struct {
    logic [7:0] data;
    logic       pkt_end;
    logic       last;
  } stream_word_t;

  // one directed row; n_words < 0 means the count is left to the packetizer model
  typedef struct {
    logic [7:0]         data;
    logic               audio;
    logic               start;
    logic [LenBits-1:0] len;
    logic [31:0]        ms;
    int                 n_words;
  } media_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         byte_value_i = '0;
  logic               is_audio_i = 1'b0;
  logic               unit_start_i = 1'b0;
  logic [LenBits-1:0] unit_length_i = '0;
  logic [31:0]        time_ms_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         out_byte_o;
  logic               packet_end_o;
  logic               run_last_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = rhap_pkg::CfgMaxPayload;
  logic [31:0]        cfg_data_i = '0;

  rtp_h264_aac_packetizer_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .byte_value_i, .is_audio_i,
    .unit_start_i, .unit_length_i, .time_ms_i, .out_valid_o, .out_ready_i,
    .out_byte_o, .packet_end_o, .run_last_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // packetizer model: registers and stream state
  // ---------------------------------------------------------------------------
  logic [15:0]        max_pl;
  logic [6:0]         video_pt, audio_pt;
  logic [31:0]        video_ssrc, audio_ssrc;
  logic [7:0]         video_chan, audio_chan;

  logic [15:0]        video_seq, audio_seq;
  logic [LenBits-1:0] nal_offset, nal_total;
  logic [15:0]        frag_fill, frag_len;
  logic [7:0]         nal_head;
  logic               nal_open;
  logic [31:0]        video_ms, audio_ms;
  logic [2:0]         adts_idx;
  logic [12:0]        adts_len, au_left;

  stream_word_t       pending_words[$];   // words the packetizer still owes
  stream_word_t       step_words[$];      // words caused by the current input word
  int                 errors = 0;
  int                 cycles = 0;
  int                 media_count = 0;
  bit                 hold_req = 1'b0;    // receiver holds off for a long stretch
  bit                 quiet = 1'b0;       // no idling on either side

  function automatic void model_reset();
    max_pl = 16'd8100; video_pt = 7'd96; audio_pt = 7'd97;
    video_ssrc = 32'd10000; audio_ssrc = 32'd20000;
    video_chan = 8'd0; audio_chan = 8'd2;
    video_seq = 16'd0; audio_seq = 16'd10000;
    nal_offset = '0; nal_total = '0; frag_fill = '0; frag_len = '0;
    nal_head = '0; nal_open = 1'b0; video_ms = '0; audio_ms = '0;
    adts_idx = '0; adts_len = '0; au_left = '0;
  endfunction

  function automatic void emit(logic [7:0] d, logic e);
    stream_word_t w;
    w.data = d; w.pkt_end = e; w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  // interleave header plus rtp header, 16 words
  function automatic void emit_head(logic [7:0] chan, logic [15:0] len, logic mark,
                                    logic [6:0] pt, logic [15:0] seq, logic [31:0] ts,
                                    logic [31:0] ssrc);
    emit(rhap_pkg::InterleaveMagic, 1'b0); emit(chan, 1'b0);
    emit(len[15:8], 1'b0); emit(len[7:0], 1'b0);
    emit(rhap_pkg::RtpVersionByte, 1'b0); emit({mark, pt}, 1'b0);
    emit(seq[15:8], 1'b0); emit(seq[7:0], 1'b0);
    emit(ts[31:24], 1'b0); emit(ts[23:16], 1'b0); emit(ts[15:8], 1'b0);
    emit(ts[7:0], 1'b0);
    emit(ssrc[31:24], 1'b0); emit(ssrc[23:16], 1'b0); emit(ssrc[15:8], 1'b0);
    emit(ssrc[7:0], 1'b0);
  endfunction

  function automatic void video_word(logic [7:0] b);
    logic [31:0]        ts;
    logic [7:0]         fu_ind, fu_type;
    logic [31:0]        sum;
    logic [LenBits-1:0] rem;
    logic               fin;
    logic [31:0]        plen;
    ts = video_ms * 32'd90;
    fu_type = {3'b000, nal_head[4:0]};
    fu_ind = {nal_head[7:5], 5'd0} | rhap_pkg::FuaType;
    if (nal_total <= LenBits'(frag_len)) begin
      // whole unit fits one single-nal packet
      if (nal_offset == '0) begin
        sum = 32'(nal_total) + 32'd12;
        emit_head(video_chan, sum[15:0], 1'b1, video_pt, video_seq, ts, video_ssrc);
        video_seq++;
      end
      emit(b, (nal_offset + 1'b1) == nal_total);
    end else if (nal_offset == '0) begin
      // first fragment drops the nal header byte
      sum = 32'(frag_len) + 32'd13;
      emit_head(video_chan, sum[15:0], 1'b0, video_pt, video_seq, ts, video_ssrc);
      video_seq++;
      emit(fu_ind, 1'b0);
      emit(8'h80 | fu_type, 1'b0);
      frag_fill = 16'd1;
    end else begin
      if (frag_fill >= frag_len) begin
        rem = nal_total - nal_offset;
        fin = rem <= LenBits'(frag_len);
        plen = fin ? 32'(rem) : 32'(frag_len);
        sum = plen + 32'd14;
        emit_head(video_chan, sum[15:0], fin, video_pt, video_seq, ts, video_ssrc);
        video_seq++;
        emit(fu_ind, 1'b0);
        emit((fin ? 8'h40 : 8'h00) | fu_type, 1'b0);
        frag_fill = '0;
      end
      frag_fill++;
      emit(b, frag_fill >= frag_len || (nal_offset + 1'b1) == nal_total);
    end
    nal_offset++;
    if (nal_offset >= nal_total || nal_offset == '0) nal_open = 1'b0;
  endfunction

  function automatic void audio_word(logic [7:0] b);
    logic [12:0] pl;
    if (au_left > 0) begin
      au_left--;
      emit(b, au_left == 0);
      return;
    end
    case (adts_idx)
      3'd0: adts_len = '0;
      3'd3: adts_len = {b[1:0], 11'd0};
      3'd4: adts_len = adts_len | {2'b00, b, 3'b000};
      3'd5: adts_len = adts_len | {10'd0, b[7:5]};
      default: ;
    endcase
    if (adts_idx < 3'd6) begin
      adts_idx++;
      return;
    end
    // header complete: strip it, add the au header
    adts_idx = '0;
    pl = (adts_len > 13'd7) ? adts_len - 13'd7 : '0;
    emit_head(audio_chan, 16'(pl) + 16'd16, 1'b1, audio_pt, audio_seq,
              audio_ms * 32'd16, audio_ssrc);
    audio_seq++;
    emit(8'h00, 1'b0);
    emit(rhap_pkg::AuHeadersLen, 1'b0);
    emit(pl[12:5], 1'b0);
    emit({pl[4:0], 3'b000}, pl == 0);
    au_left = pl;
  endfunction

  // work out the words one accepted media word causes
  function automatic int packetize(logic [7:0] b, logic audio, logic start,
                                   logic [LenBits-1:0] len, logic [31:0] ms);
    int n;
    step_words.delete();
    if (audio) begin
      if (start) begin
        adts_idx = '0; adts_len = '0; au_left = '0; audio_ms = ms;
      end
      audio_word(b);
    end else begin
      if (start) begin
        nal_total = len; nal_offset = '0; frag_fill = '0; nal_head = b;
        video_ms = ms;
        frag_len = (max_pl < 16'd2) ? 16'd2 : max_pl;
        nal_open = len != '0;
      end
      if (nal_open) video_word(b);
    end
    n = step_words.size();
    if (n > 0) step_words[n-1].last = 1'b1;
    foreach (step_words[i]) pending_words.push_back(step_words[i]);
    return n;
  endfunction

  function automatic void write_model_reg(logic [2:0] idx, logic [31:0] d);
    case (idx)
      rhap_pkg::CfgMaxPayload: max_pl = d[15:0];
      rhap_pkg::CfgVideoPt:    video_pt = d[6:0];
      rhap_pkg::CfgAudioPt:    audio_pt = d[6:0];
      rhap_pkg::CfgVideoSsrc:  video_ssrc = d;
      rhap_pkg::CfgAudioSsrc:  audio_ssrc = d;
      rhap_pkg::CfgVideoChan:  video_chan = d[7:0];
      rhap_pkg::CfgAudioChan:  audio_chan = d[7:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  task automatic send_media(logic [7:0] b, logic audio, logic start,
                            logic [LenBits-1:0] len, logic [31:0] ms, output int n);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_value_i <= b;
    is_audio_i <= audio;
    unit_start_i <= start;
    unit_length_i <= len;
    time_ms_i <= ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n = packetize(b, audio, start, len, ms);
    // video bytes the packetizer drops on the floor do not count
    if (audio || n > 0) media_count++;
  endtask

  // sender pauses until all owed words are out, plus back end latency
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // valid stays up for back to back writes, the caller drops it after the last
  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    write_model_reg(idx, d);
  endtask

  task automatic send_nal(int unsigned len, int unsigned cut);
    logic [31:0] ms;
    int          n;
    ms = $urandom();
    send_media(8'($urandom_range(0, 255)), 1'b0, 1'b1, LenBits'(len), ms, n);
    // cut < len leaves the unit unfinished for a restart
    for (int unsigned i = 1; i < len && i < cut; i++)
      send_media(8'($urandom_range(0, 255)), 1'b0, 1'b0, LenBits'($urandom()),
                 $urandom(), n);
  endtask

  task automatic send_adts(logic [12:0] flen, bit start, int unsigned cut);
    logic [7:0]  hdr[7];
    logic [7:0]  rnd;
    logic [31:0] ms;
    int          n;
    int unsigned pl;
    ms = $urandom();
    rnd = 8'($urandom());
    hdr[0] = 8'hff; hdr[1] = 8'hf1; hdr[2] = 8'($urandom());
    hdr[3] = {rnd[7:2], flen[12:11]};
    hdr[4] = flen[10:3];
    hdr[5] = {flen[2:0], rnd[4:0]};
    hdr[6] = 8'($urandom());
    pl = (flen > 13'd7) ? 32'(flen) - 32'd7 : 32'd0;
    for (int unsigned i = 0; i < 7 + pl && i < cut; i++)
      send_media(i < 7 ? hdr[i] : 8'($urandom()), 1'b1, start && i == 0,
                 LenBits'($urandom()), ms, n);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = quiet ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // compare every word leaving the packetizer with the oldest one owed
  always @(posedge clk_i) begin
    stream_word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $error("out_byte: no word expected, actual %0h", out_byte_o);
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (out_byte_o !== w.data) begin
          $error("out_byte: expected %0h actual %0h", w.data, out_byte_o);
          errors++;
        end
        if (packet_end_o !== w.pkt_end) begin
          $error("packet_end: expected %0b actual %0b", w.pkt_end, packet_end_o);
          errors++;
        end
        if (run_last_o !== w.last) begin
          $error("run_last: expected %0b actual %0b", w.last, run_last_o);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed rows: counts typed in where they are obvious
  // ---------------------------------------------------------------------------
  media_row_t rows[25] = '{
    // short single-nal unit right after reset
    '{8'h65, 1'b0, 1'b1, 24'd3, 32'd0, 17},
    '{8'h00, 1'b0, 1'b0, 24'd0, 32'd0, 1},
    '{8'hff, 1'b0, 1'b0, 24'hffffff, 32'hffffffff, 1},
    // stray byte with no open unit
    '{8'h5a, 1'b0, 1'b0, 24'd7, 32'd1, 0},
    // empty unit
    '{8'h41, 1'b0, 1'b1, 24'd0, 32'd5, 0},
    // adts frame of 10 bytes: 7 header, 3 payload
    '{8'hff, 1'b1, 1'b1, 24'd0, 32'hffffffff, 0},
    '{8'hf1, 1'b1, 1'b0, 24'd0, 32'd0, 0},
    '{8'h50, 1'b1, 1'b0, 24'd0, 32'd0, 0},
    '{8'h80, 1'b1, 1'b0, 24'd0, 32'd0, 0},
    '{8'h01, 1'b1, 1'b0, 24'd0, 32'd0, 0},
    '{8'h5f, 1'b1, 1'b0, 24'd0, 32'd0, 0},
    '{8'hfc, 1'b1, 1'b0, 24'd0, 32'd0, 20},
    '{8'h00, 1'b1, 1'b0, 24'd0, 32'd0, 1},
    '{8'haa, 1'b1, 1'b0, 24'd0, 32'd0, 1},
    '{8'hff, 1'b1, 1'b0, 24'd0, 32'd0, 1},
    // short adts frame, length 0, empty payload
    '{8'hff, 1'b1, 1'b1, 24'd0, 32'd77, 0},
    '{8'hf1, 1'b1, 1'b0, 24'd0, 32'd0, 0},
    '{8'h50, 1'b1, 1'b0, 24'd0, 32'd0, 0},
    '{8'hfc, 1'b1, 1'b0, 24'd0, 32'd0, 0},
    '{8'h00, 1'b1, 1'b0, 24'd0, 32'd0, 0},
    '{8'h1f, 1'b1, 1'b0, 24'd0, 32'd0, 0},
    '{8'hfc, 1'b1, 1'b0, 24'd0, 32'd0, 20},
    // largest unit starts fu-a fragmentation, then a restart mid-unit
    '{8'h7c, 1'b0, 1'b1, 24'hffffff, 32'hffffffff, 18},
    '{8'h33, 1'b0, 1'b0, 24'd0, 32'd0, 1},
    '{8'h67, 1'b0, 1'b1, 24'd2, 32'd9, -1}
  };

  // register settings per random phase, extremes among them
  logic [31:0] phase_regs[6][7] = '{
    '{32'd2,     32'd0,   32'd127, 32'h0,        32'hffffffff, 32'd0,   32'd255},
    '{32'd0,     32'd127, 32'd0,   32'hffffffff, 32'h0,        32'd255, 32'd0},
    '{32'd1,     32'd33,  32'd64,  32'h12345678, 32'h9abcdef0, 32'd17,  32'd42},
    '{32'd5,     32'd96,  32'd97,  32'h5555aaaa, 32'haaaa5555, 32'd1,   32'd3},
    '{32'd65535, 32'd1,   32'd126, 32'd10000,    32'd20000,    32'd128, 32'd127},
    '{32'd3,     32'd100, 32'd11,  32'hdeadbeef, 32'h0badf00d, 32'd254, 32'd1}
  };

  initial begin
    int n;
    int unsigned pick;
    model_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_media(rows[i].data, rows[i].audio, rows[i].start, rows[i].len, rows[i].ms, n);
      if (rows[i].n_words >= 0 && n != rows[i].n_words) begin
        $error("word count: expected %0d actual %0d", rows[i].n_words, n);
        errors++;
      end
    end
    drain();

    media_count = 0;
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 7; r++) write_reg(3'(r), phase_regs[ph][r]);
      cfg_valid_i <= 1'b0;
      quiet = (ph == 3);
      // long receiver hold-off while the sender keeps offering words
      if (ph == 2) hold_req = 1'b1;
      while (media_count < (ph + 1) * RandItems / 6) begin
        pick = $urandom_range(0, 19);
        if (pick < 8)
          send_nal($urandom_range(1, 12), 1000);
        else if (pick < 14)
          send_adts(13'($urandom_range(0, 20)), $urandom_range(0, 3) != 0, 1000);
        else if (pick == 14)
          send_nal($urandom_range(0, (1 << LenBits) - 1), $urandom_range(1, 6));
        else if (pick == 15)
          send_adts(13'($urandom()), 1'b1, $urandom_range(1, 12));
        else if (pick == 16)
          send_nal($urandom_range(8, 30), $urandom_range(1, 30));
        else
          // noise: random bytes of either kind
          send_media(8'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     LenBits'($urandom_range(0, 3)), $urandom(), n);
      end
      drain();
    end

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
